>>> rtl/dctd_pkg.sv
// ----------------------------------------------------------------------------
// dctd_pkg
// Shared types and constants of the DMX channel trigger detector.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int unsigned CHANNELS_PER_UNIVERSE = 512;
  localparam logic [7:0]  EDGE_LEVEL            = 8'd128;
  localparam int unsigned PROD_W                = 42;
  localparam int unsigned QEST_W                = PROD_W - 8;
  localparam int unsigned REM_W                 = 11;

  localparam logic [9:0]         START_RESET = 10'd0;
  localparam logic [9:0]         COUNT_RESET = 10'd1;
  localparam logic signed [31:0] SMIN_RESET  = 32'sd0;
  localparam logic signed [31:0] SMAX_RESET  = 32'sh00FF_0000;

  typedef enum logic [2:0] {
    CFG_MAP_UNIVERSE  = 3'd0,
    CFG_START_CHANNEL = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_TRIGGER_KIND  = 3'd3,
    CFG_SCALE_MIN     = 3'd4,
    CFG_SCALE_MAX     = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_EDGE       = 2'd0,
    KIND_CONTINUOUS = 2'd1,
    KIND_CUE_SLOT   = 2'd2,
    KIND_CUE_BLOCK  = 2'd3
  } trig_kind_e;

  typedef struct packed {
    logic [14:0] universe;
    logic [8:0]  channel_index;
    logic [7:0]  level_before;
    logic [7:0]  level_after;
    logic        frame_last;
  } dctd_in_t;

  typedef struct packed {
    logic [9:0]         channel_number;
    logic [7:0]         raw_level;
    logic signed [31:0] value_fixed;
    logic signed [31:0] cue_fixed;
  } dctd_out_t;

  typedef struct packed {
    logic [14:0]        map_universe;
    logic [9:0]         start_channel;
    logic [9:0]         channel_count;
    trig_kind_e         trigger_kind;
    logic signed [31:0] scale_min;
    logic signed [31:0] scale_max;
  } dctd_cfg_t;

  typedef struct packed {
    logic        fire;
    logic        set_edge;
    logic        sel_val_scaled;
    logic        sel_cue_scaled;
    logic [9:0]  chan;
    logic [31:0] cue_base;
  } dctd_hit_t;

endpackage

>>> rtl/dctd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dctd_cfg_regs
// Mapping configuration registers, written through an indexed write port.
// ----------------------------------------------------------------------------
module dctd_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  input  logic [2:0]          wr_index_i,
  input  logic [31:0]         wr_data_i,
  output dctd_pkg::dctd_cfg_t cfg_o
);

  dctd_pkg::dctd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_universe  <= 15'd0;
      cfg_q.start_channel <= dctd_pkg::START_RESET;
      cfg_q.channel_count <= dctd_pkg::COUNT_RESET;
      cfg_q.trigger_kind  <= dctd_pkg::KIND_EDGE;
      cfg_q.scale_min     <= dctd_pkg::SMIN_RESET;
      cfg_q.scale_max     <= dctd_pkg::SMAX_RESET;
    end else if (wr_valid_i) begin
      case (dctd_pkg::cfg_index_e'(wr_index_i))
        dctd_pkg::CFG_MAP_UNIVERSE:  cfg_q.map_universe  <= wr_data_i[14:0];
        dctd_pkg::CFG_START_CHANNEL: cfg_q.start_channel <= wr_data_i[9:0];
        dctd_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= wr_data_i[9:0];
        dctd_pkg::CFG_TRIGGER_KIND:
          cfg_q.trigger_kind <= dctd_pkg::trig_kind_e'(wr_data_i[1:0]);
        dctd_pkg::CFG_SCALE_MIN:     cfg_q.scale_min     <= $signed(wr_data_i);
        dctd_pkg::CFG_SCALE_MAX:     cfg_q.scale_max     <= $signed(wr_data_i);
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/dctd_match.sv
// ----------------------------------------------------------------------------
// dctd_match
// Block bounds, edge detection and per-mode trigger decision for one sample.
// ----------------------------------------------------------------------------
module dctd_match (
  input  dctd_pkg::dctd_cfg_t cfg_i,
  input  dctd_pkg::dctd_in_t  item_i,
  input  logic                edge_fired_i,
  output dctd_pkg::dctd_hit_t hit_o
);

  logic        enabled;
  logic [9:0]  first;
  logic [10:0] end_raw;
  logic [10:0] end_clamped;
  logic [9:0]  idx;
  logic        in_block;
  logic        at_first;
  logic        rises;
  logic        changed;
  logic [9:0]  offset1;

  assign enabled = (item_i.universe == cfg_i.map_universe) &&
                   (cfg_i.start_channel != 10'd0) &&
                   (11'(cfg_i.start_channel) <= 11'(dctd_pkg::CHANNELS_PER_UNIVERSE));
  assign first       = cfg_i.start_channel - 10'd1;
  assign end_raw     = 11'(first) + 11'(cfg_i.channel_count);
  assign end_clamped = (end_raw > 11'(dctd_pkg::CHANNELS_PER_UNIVERSE)) ?
                       11'(dctd_pkg::CHANNELS_PER_UNIVERSE) : end_raw;
  assign idx         = 10'(item_i.channel_index);
  assign in_block    = (idx >= first) && (11'(idx) < end_clamped);
  assign at_first    = (idx == first);
  assign rises       = (item_i.level_before < dctd_pkg::EDGE_LEVEL) &&
                       (item_i.level_after >= dctd_pkg::EDGE_LEVEL);
  assign changed     = (item_i.level_before != item_i.level_after);
  assign offset1     = idx - first + 10'd1;

  always_comb begin
    hit_o                = '0;
    hit_o.chan           = idx + 10'd1;
    case (cfg_i.trigger_kind)
      dctd_pkg::KIND_EDGE: begin
        hit_o.fire     = enabled && in_block && !edge_fired_i && rises;
        hit_o.set_edge = hit_o.fire;
      end
      dctd_pkg::KIND_CONTINUOUS: begin
        hit_o.fire           = enabled && at_first && changed;
        hit_o.chan           = cfg_i.start_channel;
        hit_o.sel_val_scaled = 1'b1;
      end
      dctd_pkg::KIND_CUE_SLOT: begin
        hit_o.fire           = enabled && at_first && changed &&
                               (item_i.level_after != 8'd0);
        hit_o.chan           = cfg_i.start_channel;
        hit_o.sel_cue_scaled = 1'b1;
      end
      dctd_pkg::KIND_CUE_BLOCK: begin
        hit_o.fire     = enabled && in_block && rises;
        hit_o.cue_base = {6'd0, offset1, 16'd0};
      end
      default: begin
        hit_o.fire = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/dmx_channel_trigger_detector_unit.sv
// ----------------------------------------------------------------------------
// dmx_channel_trigger_detector_unit
// Watches one universe channel block and emits trigger events from a
// stream of frame channel samples.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------
//  in      | in_data_i (dctd_in_t)                     | in_valid_i/in_stall_o
//  out     | out_data_o (dctd_out_t)                   | out_valid_o/out_stall_i
//  cfg     | cfg_index_i, cfg_data_i                   | cfg_valid_i/cfg_ready_o
//
//  One sample per cycle sustained while the output is not stalled; a trigger
//  passes the input register, product, reciprocal sum, remainder and output
//  register in that order. Non-firing samples leave the pipe after the input
//  register. Stages compress bubbles, so input is taken while a result waits.
//  Reset clears all valid bits, the once-per-frame flag and the cfg registers.
// ----------------------------------------------------------------------------
module dmx_channel_trigger_detector_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dctd_pkg::dctd_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dctd_pkg::dctd_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned PW = dctd_pkg::PROD_W;
  localparam int unsigned QW = dctd_pkg::QEST_W;
  localparam int unsigned RW = dctd_pkg::REM_W;

  dctd_pkg::dctd_cfg_t cfg;
  dctd_pkg::dctd_hit_t hit;

  logic rdy_o, rdy3, rdy2, rdy1, rdy0;
  logic adv0;

  logic               v0_q;
  dctd_pkg::dctd_in_t item0_q;
  logic               edge_q, edge_d;

  logic                 v1_q, v2_q, v3_q, vo_q;
  logic [9:0]           chan1_q, chan2_q, chan3_q;
  logic [7:0]           raw1_q, raw2_q, raw3_q;
  logic                 sv1_q, sv2_q, sv3_q;
  logic                 sc1_q, sc2_q, sc3_q;
  logic [31:0]          cb1_q, cb2_q, cb3_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW-1:0] t2_q;
  logic signed [QW-1:0] qe3_q;
  logic signed [RW-1:0] r3_q;
  dctd_pkg::dctd_out_t  out_q;

  logic signed [32:0]   diff;
  logic signed [PW-1:0] diff_w;
  logic signed [8:0]    raw_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] t_sum;
  logic signed [QW-1:0] qe;
  logic signed [PW-1:0] qe_w;
  logic signed [PW-1:0] rem_w;
  logic signed [QW-1:0] q_fix;
  logic signed [QW-1:0] scaled_w;
  logic [31:0]          scaled;
  logic [31:0]          raw_q16;

  dctd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dctd_match u_match (
    .cfg_i        (cfg),
    .item_i       (item0_q),
    .edge_fired_i (edge_q),
    .hit_o        (hit)
  );

  assign cfg_ready_o = 1'b1;

  assign rdy_o      = !vo_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy_o;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign adv0       = v0_q && rdy1;

  assign edge_d = (edge_q || hit.set_edge) && !item0_q.frame_last;

  assign diff   = 33'(cfg.scale_max) - 33'(cfg.scale_min);
  assign diff_w = PW'(diff);
  assign raw_s  = $signed({1'b0, item0_q.level_after});
  assign prod   = diff_w * raw_s;

  assign t_sum = p1_q + (p1_q >>> 8) + (p1_q >>> 16) + (p1_q >>> 24) + (p1_q >>> 32);

  assign qe    = t2_q[PW-1:8];
  assign qe_w  = PW'(qe);
  assign rem_w = p2_q - {qe, 8'd0} + qe_w;

  always_comb begin
    q_fix = qe3_q;
    if (r3_q >= RW'(255)) begin
      q_fix = qe3_q + QW'(1);
    end else if (r3_q[RW-1]) begin
      q_fix = qe3_q - QW'(1);
    end
  end

  assign scaled_w = QW'(cfg.scale_min) + q_fix;
  assign scaled   = scaled_w[31:0];
  assign raw_q16  = {8'd0, raw3_q, 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
      edge_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (adv0) begin
        edge_q <= edge_d;
      end
      if (rdy1) begin
        v1_q <= v0_q && hit.fire;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_o) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      item0_q <= in_data_i;
    end
    if (rdy1) begin
      chan1_q <= hit.chan;
      raw1_q  <= item0_q.level_after;
      sv1_q   <= hit.sel_val_scaled;
      sc1_q   <= hit.sel_cue_scaled;
      cb1_q   <= hit.cue_base;
      p1_q    <= prod;
    end
    if (rdy2) begin
      chan2_q <= chan1_q;
      raw2_q  <= raw1_q;
      sv2_q   <= sv1_q;
      sc2_q   <= sc1_q;
      cb2_q   <= cb1_q;
      p2_q    <= p1_q;
      t2_q    <= t_sum;
    end
    if (rdy3) begin
      chan3_q <= chan2_q;
      raw3_q  <= raw2_q;
      sv3_q   <= sv2_q;
      sc3_q   <= sc2_q;
      cb3_q   <= cb2_q;
      qe3_q   <= qe;
      r3_q    <= rem_w[RW-1:0];
    end
    if (rdy_o) begin
      out_q.channel_number <= chan3_q;
      out_q.raw_level      <= raw3_q;
      out_q.value_fixed    <= sv3_q ? $signed(scaled) : $signed(raw_q16);
      out_q.cue_fixed      <= sc3_q ? $signed(scaled) : $signed(cb3_q);
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && v1_q && v2_q && v3_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_frame_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv0 && item0_q.frame_last) |=> !edge_q)
    else $error("once-per-frame flag survived the frame end");

  a_chan_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.channel_number != 10'd0))
    else $error("trigger with channel number zero");

  a_edge_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv0 && edge_q && !item0_q.frame_last) |=> edge_q)
    else $error("once-per-frame flag dropped inside a frame");

endmodule
